@@ rtl/kscm_pkg.sv @@
// ----------------------------------------------------------------------------
// Key scan MIDI event package
// Shared sizes, opcodes, register indexes, the job type passed from the
// front end to the event sequencer, and a small bit-search helper.
// ----------------------------------------------------------------------------
package kscm_pkg;

  // Keyboard and control geometry.
  localparam int HALF_BOARDS       = 4;
  localparam int BUFFERS_PER_BOARD = 8;
  localparam int CONTROLS          = 4;
  localparam int KEY_SLOTS         = HALF_BOARDS * BUFFERS_PER_BOARD;
  localparam int SLOT_W            = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_CHANNELS     = 3'd0;
  localparam logic [2:0] REG_KEY_OFFSETS      = 3'd1;
  localparam logic [2:0] REG_CONTROL_CHANNELS = 3'd2;
  localparam logic [2:0] REG_CONTROL_NUMBERS  = 3'd3;
  localparam logic [2:0] REG_ADC_SHIFTS       = 3'd4;

  // Request types.
  localparam logic REQ_KEY     = 1'b0;
  localparam logic REQ_CONTROL = 1'b1;

  // MIDI opcodes and fixed velocity.
  localparam logic [7:0] OP_NOTE_OFF    = 8'b1000_0000;
  localparam logic [7:0] OP_NOTE_ON     = 8'b1001_0000;
  localparam logic [7:0] OP_CTRL_CHANGE = 8'b1011_0000;
  localparam logic [7:0] KEY_VELOCITY   = 8'h40;

  // One unit of work for the event sequencer. For a key job, mask holds the
  // changed keys and level the new contact levels; base is the note number of
  // bit 0. For a control job, mask has only bit 0 set, base is the controller
  // number and level is the new control value.
  typedef struct packed {
    logic       is_ctrl;
    logic [3:0] chan;
    logic [7:0] base;
    logic [7:0] mask;
    logic [7:0] level;
  } job_t;

  // Index of the lowest set bit of an 8-bit mask (zero for an empty mask).
  function automatic logic [2:0] lowest_bit(input logic [7:0] mask);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/kscm_in_if.sv @@
// ----------------------------------------------------------------------------
// Key scan input channel
// Valid/ready channel carrying one key or control sample request.
// ----------------------------------------------------------------------------
interface kscm_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] board_index;
  logic [2:0] buffer_index;
  logic [7:0] key_bits;
  logic [1:0] control_index;
  logic [9:0] adc_sample;

  modport source (output valid, req_type, board_index, buffer_index, key_bits,
                  control_index, adc_sample, input ready);
  modport sink (input valid, req_type, board_index, buffer_index, key_bits,
                control_index, adc_sample, output ready);
endinterface

@@ rtl/kscm_out_if.sv @@
// ----------------------------------------------------------------------------
// Key scan result channel
// Valid/ready channel carrying one MIDI event.
// ----------------------------------------------------------------------------
interface kscm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [7:0] data_one;
  logic [7:0] data_two;
  logic       last;

  modport source (output valid, status_byte, data_one, data_two, last,
                  input ready);
  modport sink (input valid, status_byte, data_one, data_two, last,
                output ready);
endinterface

@@ rtl/kscm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Key scan configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface kscm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/kscm_front.sv @@
// ----------------------------------------------------------------------------
// Key scan front end
// Holds the configuration registers and both history stores, accepts a
// request, detects changes, updates history and queues a job for any change.
// ----------------------------------------------------------------------------
module kscm_front (
  input  logic                clk,
  input  logic                rst_n,
  kscm_in_if.sink             in_ch,
  kscm_cfg_if.sink            cfg_ch,
  input  logic                q_full,
  output logic                push,
  output kscm_pkg::job_t      push_job
);

  logic [15:0] key_channels_r;
  logic [31:0] key_offsets_r;
  logic [15:0] control_channels_r;
  logic [31:0] control_numbers_r;
  logic [15:0] adc_shifts_r;

  logic [7:0] key_hist_r  [kscm_pkg::KEY_SLOTS];
  logic [7:0] ctrl_hist_r [kscm_pkg::CONTROLS];

  logic                        accept;
  logic                        key_ok;
  logic                        ctl_ok;
  logic [kscm_pkg::SLOT_W-1:0] slot;
  logic [7:0]                  key_diff;
  logic [3:0]                  shift;
  logic [7:0]                  ctl_val;
  logic [7:0]                  ctl_old;
  logic                        key_wr;
  logic                        ctl_wr;

  assign in_ch.ready  = ~q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid & ~q_full;

  // Classify the request and work out what changed.
  always_comb begin
    key_ok = (32'(in_ch.board_index) < kscm_pkg::HALF_BOARDS) &&
             (32'(in_ch.buffer_index) < kscm_pkg::BUFFERS_PER_BOARD);
    ctl_ok = 32'(in_ch.control_index) < kscm_pkg::CONTROLS;
    slot   = kscm_pkg::SLOT_W'(32'(in_ch.board_index) * kscm_pkg::BUFFERS_PER_BOARD +
                               32'(in_ch.buffer_index));
    key_diff = key_ok ? (key_hist_r[slot] ^ in_ch.key_bits) : 8'h00;
    shift    = adc_shifts_r[in_ch.control_index*4 +: 4];
    ctl_val  = 8'(in_ch.adc_sample >> shift);
    ctl_old  = ctl_ok ? ctrl_hist_r[in_ch.control_index[$clog2(kscm_pkg::CONTROLS > 1 ?
                                    kscm_pkg::CONTROLS : 2)-1:0]] : 8'h00;

    key_wr = accept && (in_ch.req_type == kscm_pkg::REQ_KEY) && key_ok;
    ctl_wr = accept && (in_ch.req_type == kscm_pkg::REQ_CONTROL) && ctl_ok &&
             (ctl_val != ctl_old);

    push_job = '0;
    if (in_ch.req_type == kscm_pkg::REQ_CONTROL) begin
      push_job.is_ctrl = 1'b1;
      push_job.chan    = control_channels_r[in_ch.control_index*4 +: 4];
      push_job.base    = control_numbers_r[in_ch.control_index*8 +: 8];
      push_job.mask    = 8'h01;
      push_job.level   = ctl_val;
    end else begin
      push_job.is_ctrl = 1'b0;
      push_job.chan    = key_channels_r[in_ch.board_index*4 +: 4];
      push_job.base    = 8'({in_ch.buffer_index, 3'b000}) +
                         key_offsets_r[in_ch.board_index*8 +: 8];
      push_job.mask    = key_diff;
      push_job.level   = in_ch.key_bits;
    end
    push = ctl_wr || (key_wr && (key_diff != 8'h00));
  end

  // Configuration register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_channels_r     <= '0;
      key_offsets_r      <= '0;
      control_channels_r <= '0;
      control_numbers_r  <= '0;
      adc_shifts_r       <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        kscm_pkg::REG_KEY_CHANNELS:     key_channels_r     <= cfg_ch.data[15:0];
        kscm_pkg::REG_KEY_OFFSETS:      key_offsets_r      <= cfg_ch.data;
        kscm_pkg::REG_CONTROL_CHANNELS: control_channels_r <= cfg_ch.data[15:0];
        kscm_pkg::REG_CONTROL_NUMBERS:  control_numbers_r  <= cfg_ch.data;
        kscm_pkg::REG_ADC_SHIFTS:       adc_shifts_r       <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // History stores, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kscm_pkg::KEY_SLOTS; i++) key_hist_r[i] <= 8'h00;
      for (int i = 0; i < kscm_pkg::CONTROLS; i++) ctrl_hist_r[i] <= 8'h00;
    end else begin
      if (key_wr) key_hist_r[slot] <= in_ch.key_bits;
      if (ctl_wr) begin
        ctrl_hist_r[in_ch.control_index[$clog2(kscm_pkg::CONTROLS > 1 ?
                    kscm_pkg::CONTROLS : 2)-1:0]] <= ctl_val;
      end
    end
  end

endmodule

@@ rtl/kscm_queue.sv @@
// ----------------------------------------------------------------------------
// Key scan job queue
// Two-entry FIFO of jobs between the front end and the event sequencer.
// ----------------------------------------------------------------------------
module kscm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kscm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output kscm_pkg::job_t head_job
);

  kscm_pkg::job_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = entry_r[rd_ptr_r];

  // Occupancy tracking.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

endmodule

@@ rtl/kscm_back.sv @@
// ----------------------------------------------------------------------------
// Key scan event sequencer
// Takes jobs from the queue and emits one MIDI event per cycle through an
// output register while the event channel accepts, lowest changed key first.
// ----------------------------------------------------------------------------
module kscm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  kscm_pkg::job_t head_job,
  output logic           pop,
  kscm_out_if.source     out_ch
);

  logic           cur_valid_r;
  logic           cur_valid_nxt;
  kscm_pkg::job_t cur_r;
  logic [7:0]     rem_nxt;

  logic       out_valid_r;
  logic [7:0] status_r;
  logic [7:0] data_one_r;
  logic [7:0] data_two_r;
  logic       last_r;

  logic       out_free;
  logic       emit;
  logic       done;
  logic [2:0] bit_idx;
  logic [7:0] ev_status;
  logic [7:0] ev_data_one;
  logic [7:0] ev_data_two;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status_byte = status_r;
  assign out_ch.data_one    = data_one_r;
  assign out_ch.data_two    = data_two_r;
  assign out_ch.last        = last_r;

  // Pick the next event of the current job.
  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    emit     = cur_valid_r && out_free;
    bit_idx  = kscm_pkg::lowest_bit(cur_r.mask);
    rem_nxt  = cur_r.mask & (cur_r.mask - 8'd1);
    done     = (rem_nxt == 8'h00);
    pop      = head_valid && (!cur_valid_r || (emit && done));

    if (cur_r.is_ctrl) begin
      ev_status   = kscm_pkg::OP_CTRL_CHANGE | {4'h0, cur_r.chan};
      ev_data_one = cur_r.base;
      ev_data_two = cur_r.level;
    end else begin
      ev_status   = (cur_r.level[bit_idx] ? kscm_pkg::OP_NOTE_ON : kscm_pkg::OP_NOTE_OFF) |
                    {4'h0, cur_r.chan};
      ev_data_one = cur_r.base + {5'd0, bit_idx};
      ev_data_two = kscm_pkg::KEY_VELOCITY;
    end

    cur_valid_nxt = cur_valid_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
    end else if (emit && done) begin
      cur_valid_nxt = 1'b0;
    end
  end

  // Current job and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Job payload and event payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_job;
    end else if (emit) begin
      cur_r.mask <= rem_nxt;
    end
    if (emit) begin
      status_r   <= ev_status;
      data_one_r <= ev_data_one;
      data_two_r <= ev_data_two;
      last_r     <= done;
    end
  end

endmodule

@@ rtl/key_scan_midi_event_generator.sv @@
// ----------------------------------------------------------------------------
// Key scan MIDI event generator
// Turns key buffer samples and control ADC samples into MIDI events.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry job queue has room; the front end
// compares it with the stored history at once and updates that history. A key
// request with n changed keys yields n events and a control request whose
// value changed yields one; the sequencer emits one event per cycle through
// the single event output register while the event channel accepts them.
// Requests that change nothing, or that name a board, buffer or control that
// does not exist, leave no events. Both histories and all configuration
// registers are zero after reset, and configuration writes are always taken.
module key_scan_midi_event_generator (
  input  logic       clk,
  input  logic       rst_n,
  kscm_in_if.sink    in_ch,
  kscm_cfg_if.sink   cfg_ch,
  kscm_out_if.source out_ch
);

  logic           q_full;
  logic           push;
  kscm_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  kscm_pkg::job_t head_job;

  // Request intake and change detection.
  kscm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Job queue between the two halves.
  kscm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Event sequencing and output register.
  kscm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ tb/midi_event_checker.sv @@
// ----------------------------------------------------------------------------
// MIDI event checker
// Watches the request, configuration and event channels of the key scan
// MIDI event generator. It keeps its own copy of the registers and of the key
// and control histories, predicts the events that each accepted request must
// cause, and compares every accepted event with the oldest prediction.
// ----------------------------------------------------------------------------
module midi_event_checker import kscm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  kscm_in_if   req_mon,
  kscm_cfg_if  cfg_mon,
  kscm_out_if  midi_mon,
  output int   error_count,
  output int   events_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic       last;
  } midi_event_t;

  // Shadow registers and histories.
  logic [15:0] key_chan_reg;
  logic [31:0] key_offs_reg;
  logic [15:0] ctl_chan_reg;
  logic [31:0] ctl_num_reg;
  logic [15:0] shift_reg;
  logic [7:0]  key_seen [KEY_SLOTS];
  logic [7:0]  ctl_seen [CONTROLS];

  midi_event_t pending_events [$];
  midi_event_t got;
  midi_event_t want;

  // Works out the events caused by one request and updates the histories.
  task automatic predict_events(input logic rtype, input logic [1:0] board,
                                input logic [2:0] buf_idx, input logic [7:0] bits,
                                input logic [1:0] ctl, input logic [9:0] adc);
    int          slot;
    logic [7:0]  changed;
    logic [3:0]  chan;
    logic [7:0]  offs;
    logic [7:0]  level;
    midi_event_t ev;
    if (rtype == REQ_KEY) begin
      // Requests naming a board or buffer that does not exist are dropped.
      if (int'(board) >= HALF_BOARDS || int'(buf_idx) >= BUFFERS_PER_BOARD) return;
      slot = int'(board) * BUFFERS_PER_BOARD + int'(buf_idx);
      changed = key_seen[slot] ^ bits;
      key_seen[slot] = bits;
      chan = key_chan_reg[board * 4 +: 4];
      offs = key_offs_reg[board * 8 +: 8];
      // One note event per changed key, lowest bit first; note numbers wrap.
      for (int j = 0; j < 8; j++) begin
        if (changed[j]) begin
          ev.status   = (bits[j] ? OP_NOTE_ON : OP_NOTE_OFF) | {4'h0, chan};
          ev.data_one = 8'(int'(buf_idx) * 8 + j) + offs;
          ev.data_two = KEY_VELOCITY;
          ev.last     = ((changed >> (j + 1)) == 8'h00);
          pending_events.push_back(ev);
        end
      end
    end else begin
      if (int'(ctl) >= CONTROLS) return;
      level = 8'(adc >> shift_reg[ctl * 4 +: 4]);
      // A control value that did not move produces nothing.
      if (level != ctl_seen[ctl]) begin
        ctl_seen[ctl] = level;
        ev.status   = OP_CTRL_CHANGE | {4'h0, ctl_chan_reg[ctl * 4 +: 4]};
        ev.data_one = ctl_num_reg[ctl * 8 +: 8];
        ev.data_two = level;
        ev.last     = 1'b1;
        pending_events.push_back(ev);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_chan_reg = '0;
      key_offs_reg = '0;
      ctl_chan_reg = '0;
      ctl_num_reg  = '0;
      shift_reg    = '0;
      foreach (key_seen[i]) key_seen[i] = '0;
      foreach (ctl_seen[i]) ctl_seen[i] = '0;
      pending_events.delete();
      error_count = 0;
    end else begin
      // Register writes keep only each register's width; spare indexes do nothing.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_KEY_CHANNELS:     key_chan_reg = cfg_mon.data[15:0];
          REG_KEY_OFFSETS:      key_offs_reg = cfg_mon.data;
          REG_CONTROL_CHANNELS: ctl_chan_reg = cfg_mon.data[15:0];
          REG_CONTROL_NUMBERS:  ctl_num_reg  = cfg_mon.data;
          REG_ADC_SHIFTS:       shift_reg    = cfg_mon.data[15:0];
          default: ;
        endcase
      end

      if (req_mon.valid && req_mon.ready) begin
        predict_events(req_mon.req_type, req_mon.board_index, req_mon.buffer_index,
                       req_mon.key_bits, req_mon.control_index, req_mon.adc_sample);
      end

      // Each delivered event must match the oldest outstanding prediction.
      if (midi_mon.valid && midi_mon.ready) begin
        got = '{midi_mon.status_byte, midi_mon.data_one, midi_mon.data_two,
                midi_mon.last};
        if (pending_events.size() == 0) begin
          if (error_count < 10) begin
            $display("unexpected MIDI event: status %02h data %02h %02h last %0b",
                     got.status, got.data_one, got.data_two, got.last);
          end
          error_count++;
        end else begin
          want = pending_events.pop_front();
          if (got.status !== want.status || got.data_one !== want.data_one ||
              got.data_two !== want.data_two || got.last !== want.last) begin
            if (error_count < 10) begin
              $display("MIDI event mismatch: expected %02h %02h %02h last %0b, got %02h %02h %02h last %0b",
                       want.status, want.data_one, want.data_two, want.last,
                       got.status, got.data_one, got.data_two, got.last);
            end
            error_count++;
          end
        end
      end
    end
    events_owed = pending_events.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Key scan MIDI event generator testbench
// Drives key and control samples in bursts with random gaps, stalls the event
// channel on its own pattern, and steps through several register settings.
// The checker predicts and compares; this module makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kscm_pkg::*;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEMS_PER_PHASE = 65;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BLOCKED} sink_mode_t;

  logic clk;
  logic rst_n;
  int   fail_total;
  int   events_owed;

  kscm_in_if  req_ch();
  kscm_cfg_if cfg_ch();
  kscm_out_if midi_ch();

  key_scan_midi_event_generator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .cfg_ch (cfg_ch),
    .out_ch (midi_ch)
  );

  midi_event_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .cfg_mon     (cfg_ch),
    .midi_mon    (midi_ch),
    .error_count (fail_total),
    .events_owed (events_owed)
  );

  // What was last sent per slot and control, to bias toward small changes.
  logic [7:0] key_sent [KEY_SLOTS];
  logic [9:0] adc_sent [CONTROLS];
  int         burst_left;
  bit         steady_sender;
  sink_mode_t sink_mode;
  int         sink_span;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Event channel back-pressure: random spans of open, coin-flip, sparse and
  // fully blocked acceptance.
  always @(negedge clk) begin
    if (!rst_n) begin
      midi_ch.ready = 1'b0;
    end else begin
      if (sink_span == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_span = $urandom_range(8, 64);
      end
      sink_span--;
      case (sink_mode)
        SINK_OPEN:    midi_ch.ready = 1'b1;
        SINK_COIN:    midi_ch.ready = 1'($urandom_range(0, 1));
        SINK_SPARSE:  midi_ch.ready = ($urandom_range(0, 3) == 0);
        SINK_BLOCKED: midi_ch.ready = 1'b0;
        default:      midi_ch.ready = 1'b1;
      endcase
    end
  end

  // Sends one request, opening a new burst after a random gap when needed.
  task automatic send_req(input logic rtype, input logic [1:0] board,
                          input logic [2:0] buf_idx, input logic [7:0] bits,
                          input logic [1:0] ctl, input logic [9:0] adc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_ch.req_type      = rtype;
    req_ch.board_index   = board;
    req_ch.buffer_index  = buf_idx;
    req_ch.key_bits      = bits;
    req_ch.control_index = ctl;
    req_ch.adc_sample    = adc;
    req_ch.valid         = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (rtype == REQ_KEY) key_sent[int'(board) * BUFFERS_PER_BOARD + int'(buf_idx)] = bits;
    else adc_sent[ctl] = adc;
    burst_left--;
    @(negedge clk);
  endtask

  // One random request; mostly key samples close to what each slot holds.
  task automatic random_req();
    logic [1:0] board;
    logic [2:0] buf_idx;
    logic [7:0] bits;
    logic [1:0] ctl;
    logic [9:0] adc;
    int         slot;
    board   = 2'($urandom);
    buf_idx = 3'($urandom);
    bits    = 8'($urandom);
    ctl     = 2'($urandom);
    adc     = 10'($urandom);
    slot    = int'(board) * BUFFERS_PER_BOARD + int'(buf_idx);
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 7))
        0:       bits = 8'h00;
        1:       bits = 8'hFF;
        2:       bits = key_sent[slot];
        3, 4:    bits = key_sent[slot] ^ (8'h01 << $urandom_range(0, 7));
        5:       bits = key_sent[slot] ^ (8'h03 << $urandom_range(0, 6));
        default: ;
      endcase
      send_req(REQ_KEY, board, buf_idx, bits, ctl, adc);
    end else begin
      case ($urandom_range(0, 3))
        0:       adc = adc_sent[ctl];
        1:       adc = 10'h000;
        2:       adc = 10'h3FF;
        default: ;
      endcase
      send_req(REQ_CONTROL, board, buf_idx, bits, ctl, adc);
    end
  endtask

  // Holds requests until every predicted event is out, then lets the block
  // finish any request that produced nothing.
  task automatic settle_events();
    req_ch.valid = 1'b0;
    while (events_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic load_config(input logic [31:0] key_chans, input logic [31:0] key_offs,
                             input logic [31:0] ctl_chans, input logic [31:0] ctl_nums,
                             input logic [31:0] shifts);
    write_reg(REG_KEY_CHANNELS, key_chans);
    write_reg(REG_KEY_OFFSETS, key_offs);
    write_reg(REG_CONTROL_CHANNELS, ctl_chans);
    write_reg(REG_CONTROL_NUMBERS, ctl_nums);
    write_reg(REG_ADC_SHIFTS, shifts);
  endtask

  initial begin
    rst_n                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_KEY;
    req_ch.board_index   = '0;
    req_ch.buffer_index  = '0;
    req_ch.key_bits      = '0;
    req_ch.control_index = '0;
    req_ch.adc_sample    = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_KEY_CHANNELS;
    cfg_ch.data          = '0;
    midi_ch.ready        = 1'b0;
    burst_left           = 0;
    steady_sender        = 1'b0;
    sink_mode            = SINK_OPEN;
    sink_span            = 0;
    foreach (key_sent[i]) key_sent[i] = '0;
    foreach (adc_sent[i]) adc_sent[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset register values: channel 0, offset 0, no shift.
    send_req(REQ_KEY, 2'd2, 3'd4, 8'hA5, 2'($urandom), 10'($urandom));
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd2, 10'h3FF);
    settle_events();

    // Offsets chosen so that the top board wraps past note 255; shifts of
    // zero, two, nine and fifteen bits.
    load_config(32'h1234_F0A1, 32'hF880_1000, 32'hABCD_0F5A, 32'h7F40_0100,
                32'h0000_F920);
    write_reg(REG_SPARE_FIRST, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LAST, 32'($urandom));

    // Full press, repeat with no change, full release.
    send_req(REQ_KEY, 2'd0, 3'd0, 8'hFF, 2'($urandom), 10'($urandom));
    send_req(REQ_KEY, 2'd0, 3'd0, 8'hFF, 2'($urandom), 10'($urandom));
    send_req(REQ_KEY, 2'd0, 3'd0, 8'h00, 2'($urandom), 10'($urandom));
    // Note numbers past 255 on the last buffer of the last board.
    send_req(REQ_KEY, 2'd3, 3'd7, 8'hFF, 2'($urandom), 10'($urandom));
    send_req(REQ_KEY, 2'd3, 3'd7, 8'h5A, 2'($urandom), 10'($urandom));
    send_req(REQ_KEY, 2'd1, 3'd3, 8'h01, 2'($urandom), 10'($urandom));
    send_req(REQ_KEY, 2'd2, 3'd5, 8'h80, 2'($urandom), 10'($urandom));
    send_req(REQ_KEY, 2'd2, 3'd4, 8'h00, 2'($urandom), 10'($urandom));
    // Controls: upper ADC bits dropped, unchanged value, large shifts.
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd0, 10'h3FF);
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd0, 10'h2FF);
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd0, 10'h000);
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd1, 10'h3FF);
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd2, 10'h3FF);
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd3, 10'h3FF);
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd3, 10'h155);
    send_req(REQ_CONTROL, 2'($urandom), 3'($urandom), 8'($urandom), 2'd1, 10'h2AA);

    // Random traffic under the directed settings.
    repeat (ITEMS_PER_PHASE) random_req();
    settle_events();

    // All registers at zero, sender without gaps.
    load_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    steady_sender = 1'b1;
    repeat (ITEMS_PER_PHASE) random_req();
    steady_sender = 1'b0;
    settle_events();

    // All registers at their maximum; upper write bits must be dropped.
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
    repeat (ITEMS_PER_PHASE) random_req();
    settle_events();

    // Random settings, with shifts kept small enough to matter.
    load_config(32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                32'($urandom) & 32'h0000_3333);
    repeat (ITEMS_PER_PHASE) random_req();
    settle_events();

    if (fail_total == 0 && events_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kscm_pkg.sv
rtl/kscm_in_if.sv
rtl/kscm_out_if.sv
rtl/kscm_cfg_if.sv
rtl/kscm_front.sv
rtl/kscm_queue.sv
rtl/kscm_back.sv
rtl/key_scan_midi_event_generator.sv
tb/midi_event_checker.sv
tb/tb_top.sv
